@@ design/tdnn_layer_stream_core_defines.svh @@
// assertion macros used by the tdnn layer stream controller
`ifndef TDNN_LAYER_STREAM_CORE_DEFINES_SVH
`define TDNN_LAYER_STREAM_CORE_DEFINES_SVH

// same-cycle implication, checked on clk and masked during reset
`define TLS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TLS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/tls_pkg.sv @@
// types, constants and activation tables of the tdnn layer stream block
`timescale 1ns / 1ps
package tls_pkg;

  localparam int FEAT_MAX     = 64;
  localparam int OUT_MAX      = 32;
  localparam int HIST_FRAMES  = 32;
  localparam int ROW_STRIDE   = 512;
  localparam int WEIGHT_DEPTH = OUT_MAX * ROW_STRIDE;
  localparam int HIST_DEPTH   = HIST_FRAMES * FEAT_MAX;

  localparam int SLOT_W = 5;
  localparam int FH_W   = 6;
  localparam int ELEM_W = 6;
  localparam int ROW_W  = 5;
  localparam int WJ_W   = 9;

  localparam logic [1:0] CMD_WEIGHT = 2'd0;
  localparam logic [1:0] CMD_BIAS   = 2'd1;
  localparam logic [1:0] CMD_FEED   = 2'd2;
  localparam logic [1:0] CMD_FLUSH  = 2'd3;

  localparam logic [2:0] REG_LEFT   = 3'd0;
  localparam logic [2:0] REG_RIGHT  = 3'd1;
  localparam logic [2:0] REG_SPACE  = 3'd2;
  localparam logic [2:0] REG_ACT    = 3'd3;
  localparam logic [2:0] REG_SLOPE  = 3'd4;
  localparam logic [2:0] REG_BIAS   = 3'd5;
  localparam logic [2:0] REG_FEAT   = 3'd6;
  localparam logic [2:0] REG_OUTLEN = 3'd7;

  localparam logic [2:0] ACT_NONE  = 3'd0;
  localparam logic [2:0] ACT_SIG   = 3'd1;
  localparam logic [2:0] ACT_RELU  = 3'd2;
  localparam logic [2:0] ACT_PRELU = 3'd3;
  localparam logic [2:0] ACT_TANH  = 3'd4;

  typedef struct packed {
    logic [1:0]         command;
    logic [13:0]        address;
    logic signed [15:0] value;
    logic               end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] out_value;
    logic [4:0]         out_index;
    logic               last_of_frame;
    logic               stream_done;
  } out_item_t;

  typedef struct packed {
    logic              idle;
    logic              mac_issue;
    logic              mac_first;
    logic [ROW_W-1:0]  row;
    logic [WJ_W-1:0]   widx;
    logic [SLOT_W-1:0] toff;
    logic [ELEM_W-1:0] elem;
    logic              do_round;
    logic              do_act;
    logic              do_emit;
    logic              last_row;
  } tls_cmd_t;

  typedef struct packed {
    logic       start;
    logic       out_busy;
    logic [2:0] taps;
    logic [2:0] spacing;
    logic [6:0] frame_len;
    logic [5:0] out_len;
  } tls_status_t;

  typedef logic signed [15:0] act_lut_t [256];

  function automatic logic signed [15:0] sat16(input logic signed [40:0] v);
    logic signed [15:0] r;
    if (v > 41'sd32767) r = 16'sh7fff;
    else if (v < -41'sd32768) r = 16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

  // elaboration-time table: logistic or tanh samples at the lower edge of each bin
  function automatic act_lut_t build_act_lut(input logic tanh_sel);
    logic [63:0] p;
    logic [63:0] den;
    logic [63:0] num;
    logic [63:0] rem;
    logic [63:0] q;
    logic [31:0] ptab [257];
    logic [31:0] sg;
    logic [31:0] v;
    int          k;
    int          b;
    int          m;
    act_lut_t    lut;
    p = 64'h1_0000_0000;
    for (k = 0; k < 257; k++) begin
      den = 64'h1_0000_0000 + p;
      num = 64'h1_0000_0000_0000 + (den >> 1);
      rem = '0;
      q   = '0;
      for (b = 63; b >= 0; b--) begin
        rem = {rem[62:0], num[b]};
        if (rem >= den) begin
          rem  = rem - den;
          q[b] = 1'b1;
        end
      end
      ptab[k] = q[31:0];
      p = (p * 64'd4034748382 + 64'h8000_0000) >> 32;
    end
    for (k = 0; k < 256; k++) begin
      m = tanh_sel ? 2 * (k - 128) : k - 128;
      sg = (m >= 0) ? ptab[m] : 32'd65536 - ptab[-m];
      if (tanh_sel) v = ((2 * sg + 32'd128) >> 8) - 32'd256;
      else v = (sg + 32'd128) >> 8;
      lut[k] = v[15:0];
    end
    return lut;
  endfunction

  localparam act_lut_t SIG_LUT  = build_act_lut(1'b0);
  localparam act_lut_t TANH_LUT = build_act_lut(1'b1);

endpackage

@@ design/tls_ram.sv @@
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
module tls_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

@@ design/tls_ctrl.sv @@
// controller: sequences rows, taps and elements of one frame's dot products
`timescale 1ns / 1ps
`include "tdnn_layer_stream_core_defines.svh"
module tls_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  tls_pkg::tls_status_t status,
  output tls_pkg::tls_cmd_t    cmd
);
  import tls_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_MAC    = 7'b0000010,
    S_DRAIN1 = 7'b0000100,
    S_DRAIN2 = 7'b0001000,
    S_ROUND  = 7'b0010000,
    S_ACT    = 7'b0100000,
    S_EMIT   = 7'b1000000
  } state_t;

  state_t            state_r, state_nxt;
  logic [ROW_W-1:0]  r_r, r_nxt;
  logic [2:0]        t_r, t_nxt;
  logic [ELEM_W-1:0] k_r, k_nxt;
  logic [WJ_W-1:0]   j_r, j_nxt;
  logic [SLOT_W-1:0] toff_r, toff_nxt;
  logic              k_last, t_last, r_last;

  assign k_last = ({1'b0, k_r} == status.frame_len - 7'd1);
  assign t_last = (t_r == status.taps);
  assign r_last = ({1'b0, r_r} == status.out_len - 6'd1);

  always_comb begin
    state_nxt = state_r;
    r_nxt     = r_r;
    t_nxt     = t_r;
    k_nxt     = k_r;
    j_nxt     = j_r;
    toff_nxt  = toff_r;
    cmd       = '0;
    cmd.row      = r_r;
    cmd.widx     = j_r;
    cmd.toff     = toff_r;
    cmd.elem     = k_r;
    cmd.last_row = r_last;
    case (state_r)
      S_IDLE: begin
        cmd.idle = 1'b1;
        if (status.start) begin
          state_nxt = S_MAC;
          r_nxt     = '0;
          t_nxt     = '0;
          k_nxt     = '0;
          j_nxt     = '0;
          toff_nxt  = '0;
        end
      end
      S_MAC: begin
        cmd.mac_issue = 1'b1;
        cmd.mac_first = (t_r == 3'd0) && (k_r == '0);
        j_nxt = j_r + 1'b1;
        if (k_last) begin
          k_nxt = '0;
          if (t_last) begin
            state_nxt = S_DRAIN1;
          end else begin
            t_nxt    = t_r + 3'd1;
            toff_nxt = toff_r + SLOT_W'(status.spacing);
          end
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      S_DRAIN1: state_nxt = S_DRAIN2;
      S_DRAIN2: state_nxt = S_ROUND;
      S_ROUND: begin
        cmd.do_round = 1'b1;
        state_nxt    = S_ACT;
      end
      S_ACT: begin
        cmd.do_act = 1'b1;
        state_nxt  = S_EMIT;
      end
      S_EMIT: begin
        if (!status.out_busy) begin
          cmd.do_emit = 1'b1;
          if (r_last) begin
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_MAC;
            r_nxt     = r_r + 1'b1;
            t_nxt     = '0;
            k_nxt     = '0;
            j_nxt     = '0;
            toff_nxt  = '0;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      r_r     <= '0;
      t_r     <= '0;
      k_r     <= '0;
      j_r     <= '0;
      toff_r  <= '0;
    end else begin
      state_r <= state_nxt;
      r_r     <= r_nxt;
      t_r     <= t_nxt;
      k_r     <= k_nxt;
      j_r     <= j_nxt;
      toff_r  <= toff_nxt;
    end
  end

  `TLS_ASSERT_NEXT(a_start_enters_mac, state_r == S_IDLE && status.start, state_r == S_MAC, "start did not begin the dot product")
  `TLS_ASSERT_NOW(a_elem_in_frame, state_r == S_MAC, {1'b0, k_r} < status.frame_len, "element counter ran past the frame")
  `TLS_ASSERT_NEXT(a_last_row_idle, state_r == S_EMIT && !status.out_busy && r_last, state_r == S_IDLE, "controller kept going after the last row")

endmodule

@@ design/tls_dp.sv @@
// datapath: stores, stream bookkeeping, mac pipeline, activation, output register
`timescale 1ns / 1ps
module tls_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  tls_pkg::in_item_t    in_data,
  input  logic                 out_ready,
  output logic                 out_valid,
  output tls_pkg::out_item_t   out_data,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_addr,
  input  logic [15:0]          cfg_wdata,
  input  tls_pkg::tls_cmd_t    cmd,
  output tls_pkg::tls_status_t status
);
  import tls_pkg::*;

  // configuration
  logic [1:0]         left_r, right_r;
  logic [2:0]         space_r, act_r;
  logic signed [15:0] slope_r;
  logic               bias_en_r;
  logic [6:0]         feat_r;
  logic [5:0]         outlen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r    <= '0;
      right_r   <= '0;
      space_r   <= 3'd1;
      act_r     <= ACT_NONE;
      slope_r   <= '0;
      bias_en_r <= 1'b0;
      feat_r    <= 7'd64;
      outlen_r  <= 6'd32;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_LEFT:   left_r    <= cfg_wdata[1:0];
        REG_RIGHT:  right_r   <= cfg_wdata[1:0];
        REG_SPACE:  space_r   <= cfg_wdata[2:0];
        REG_ACT:    act_r     <= cfg_wdata[2:0];
        REG_SLOPE:  slope_r   <= cfg_wdata;
        REG_BIAS:   bias_en_r <= cfg_wdata[0];
        REG_FEAT:   feat_r    <= cfg_wdata[6:0];
        REG_OUTLEN: outlen_r  <= cfg_wdata[5:0];
        default: ;
      endcase
    end
  end

  logic [2:0] d_eff, taps;
  logic [6:0] fl_eff;
  logic [5:0] ol_eff;

  always_comb begin
    if (space_r == 3'd0) d_eff = 3'd1;
    else if (space_r > 3'd4) d_eff = 3'd4;
    else d_eff = space_r;
    if (feat_r == 7'd0) fl_eff = 7'd1;
    else if (feat_r > 7'(FEAT_MAX)) fl_eff = 7'(FEAT_MAX);
    else fl_eff = feat_r;
    if (outlen_r == 6'd0) ol_eff = 6'd1;
    else if (outlen_r > 6'(OUT_MAX)) ol_eff = 6'(OUT_MAX);
    else ol_eff = outlen_r;
    taps = {1'b0, left_r} + {1'b0, right_r};
  end

  // stream bookkeeping
  logic [FH_W-1:0]   fh_r, fh_nxt;
  logic [SLOT_W-1:0] old_r, old_nxt;
  logic [6:0]        ec_r, ec_nxt;
  logic [3:0]        flush_r, flush_nxt;
  logic [SLOT_W-1:0] base_r;
  logic              done_r;
  logic              zf_r [HIST_FRAMES];
  logic [6:0]        fill_r [HIST_FRAMES];
  logic              zf_nxt [HIST_FRAMES];
  logic [6:0]        fill_nxt [HIST_FRAMES];

  logic              accept, is_feed, is_flush, begin_f, prep, ovf, complete, window;
  logic              clear, hist_we;
  logic [5:0]        lz, span, rz;
  logic [SLOT_W-1:0] z, old1, wslot, off;
  logic [FH_W-1:0]   fh1, fh1b, fh2;
  logic [6:0]        ec_inc;
  logic [3:0]        fr;

  assign accept = in_valid && cmd.idle;

  always_comb begin
    is_feed  = (in_data.command == CMD_FEED) && (flush_r == 4'd0);
    is_flush = (in_data.command == CMD_FLUSH) && (flush_r != 4'd0);
    begin_f  = (is_feed && ec_r == 7'd0) || is_flush;
    lz       = {4'b0, left_r} * {3'b0, d_eff};
    span     = {3'b0, d_eff} * {3'b0, taps};
    rz       = {4'b0, right_r} * {3'b0, d_eff};
    fr       = rz[3:0];
    z        = (lz > 6'd31) ? 5'd31 : lz[4:0];
    prep     = begin_f && (fh_r == '0) && (left_r != 2'd0);
    fh1      = prep ? {1'b0, z} : fh_r;
    ovf      = begin_f && (fh1 >= FH_W'(HIST_FRAMES));
    old1     = ovf ? old_r + 1'b1 : old_r;
    fh1b     = ovf ? fh1 - 1'b1 : fh1;
    wslot    = old1 + fh1b[SLOT_W-1:0];
    ec_inc   = ec_r + 7'd1;
    complete = (is_feed && ec_inc >= fl_eff) || is_flush;
    fh2      = fh1b + 1'b1;
    window   = complete && (fh2 >= span + 6'd1);
    clear    = (is_flush && flush_r == 4'd1) ||
               (is_feed && complete && in_data.end_of_stream && fr == 4'd0);
    hist_we  = accept && is_feed && (ec_r < 7'(FEAT_MAX));

    fh_nxt    = fh_r;
    old_nxt   = old_r;
    ec_nxt    = ec_r;
    flush_nxt = flush_r;
    if (accept && (is_feed || is_flush)) begin
      old_nxt = window ? old1 + 1'b1 : old1;
      if (complete) fh_nxt = window ? fh2 - 1'b1 : fh2;
      else fh_nxt = fh1b;
      if (is_feed) ec_nxt = complete ? 7'd0 : ec_inc;
      if (is_flush) flush_nxt = flush_r - 4'd1;
      else if (complete && in_data.end_of_stream) flush_nxt = fr;
      if (clear) begin
        fh_nxt    = '0;
        old_nxt   = '0;
        ec_nxt    = '0;
        flush_nxt = '0;
      end
    end

    // zero-frame marks: entries at or past fill read as zero
    for (int s = 0; s < HIST_FRAMES; s++) begin
      zf_nxt[s]   = zf_r[s];
      fill_nxt[s] = fill_r[s];
      off = SLOT_W'(s) - old_r;
      if (accept && prep && off < z) begin
        zf_nxt[s]   = 1'b1;
        fill_nxt[s] = '0;
      end
      if (accept && is_flush && wslot == SLOT_W'(s)) begin
        zf_nxt[s]   = 1'b1;
        fill_nxt[s] = '0;
      end
      if (hist_we && wslot == SLOT_W'(s) && zf_r[s] && ec_inc > fill_r[s]) begin
        fill_nxt[s] = ec_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fh_r    <= '0;
      old_r   <= '0;
      ec_r    <= '0;
      flush_r <= '0;
      for (int s = 0; s < HIST_FRAMES; s++) zf_r[s] <= 1'b0;
    end else begin
      fh_r    <= fh_nxt;
      old_r   <= old_nxt;
      ec_r    <= ec_nxt;
      flush_r <= flush_nxt;
      for (int s = 0; s < HIST_FRAMES; s++) zf_r[s] <= zf_nxt[s];
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < HIST_FRAMES; s++) fill_r[s] <= fill_nxt[s];
    if (accept && window) begin
      base_r <= old1;
      done_r <= clear;
    end
  end

  // stores
  logic [15:0]       w_rdata, b_rdata, h_rdata;
  logic [SLOT_W-1:0] rd_slot;

  assign rd_slot = base_r + cmd.toff;

  tls_ram #(.WIDTH(16), .DEPTH(WEIGHT_DEPTH)) u_weight_ram (
    .clk   (clk),
    .we    (accept && in_data.command == CMD_WEIGHT),
    .waddr (in_data.address),
    .wdata (in_data.value),
    .re    (cmd.mac_issue),
    .raddr ({cmd.row, cmd.widx}),
    .rdata (w_rdata)
  );

  tls_ram #(.WIDTH(16), .DEPTH(OUT_MAX)) u_bias_ram (
    .clk   (clk),
    .we    (accept && in_data.command == CMD_BIAS && in_data.address < 14'(OUT_MAX)),
    .waddr (in_data.address[ROW_W-1:0]),
    .wdata (in_data.value),
    .re    (cmd.mac_first),
    .raddr (cmd.row),
    .rdata (b_rdata)
  );

  tls_ram #(.WIDTH(16), .DEPTH(HIST_DEPTH)) u_hist_ram (
    .clk   (clk),
    .we    (hist_we),
    .waddr ({wslot, ec_r[ELEM_W-1:0]}),
    .wdata (in_data.value),
    .re    (cmd.mac_issue),
    .raddr ({rd_slot, cmd.elem}),
    .rdata (h_rdata)
  );

  // mac pipeline: read, multiply, accumulate
  logic               v1_r, f1_r, z1_r, v2_r, f2_r;
  logic signed [31:0] prod_r;
  logic signed [39:0] acc_r;
  logic signed [15:0] h_op, w_op;

  assign h_op = z1_r ? 16'sd0 : h_rdata;
  assign w_op = w_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= cmd.mac_issue;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    f1_r   <= cmd.mac_first;
    z1_r   <= zf_r[rd_slot] && ({1'b0, cmd.elem} >= fill_r[rd_slot]);
    f2_r   <= f1_r;
    prod_r <= h_op * w_op;
    if (v2_r) acc_r <= f2_r ? 40'(prod_r) : acc_r + 40'(prod_r);
  end

  // round, activate, emit
  logic signed [15:0] s_r, bias_q, act_val;
  logic signed [31:0] pprod_r;
  logic [7:0]         bin_r;
  logic signed [40:0] sum_w, rnd_w, prl_w;

  assign bias_q = b_rdata;

  always_comb begin
    sum_w = 41'(acc_r) + (bias_en_r ? (41'(bias_q) <<< 8) : 41'sd0);
    rnd_w = (sum_w + 41'sd128) >>> 8;
    prl_w = (41'(pprod_r) + 41'sd128) >>> 8;
    case (act_r)
      ACT_SIG:   act_val = SIG_LUT[bin_r];
      ACT_RELU:  act_val = (s_r > 16'sd0) ? s_r : 16'sd0;
      ACT_PRELU: act_val = (s_r > 16'sd0) ? s_r : sat16(prl_w);
      ACT_TANH:  act_val = TANH_LUT[bin_r];
      default:   act_val = s_r;
    endcase
  end

  logic [15:0] s_shift;
  assign s_shift = s_r + 16'sd2048;

  always_ff @(posedge clk) begin
    if (cmd.do_round) s_r <= sat16(rnd_w);
    if (cmd.do_act) begin
      pprod_r <= s_r * slope_r;
      if (s_r < -16'sd2048) bin_r <= 8'd0;
      else if (s_r >= 16'sd2048) bin_r <= 8'd255;
      else bin_r <= s_shift[11:4];
    end
  end

  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.do_emit) out_valid_r <= 1'b1;
    else if (out_ready) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.do_emit) begin
      out_data.out_value     <= act_val;
      out_data.out_index     <= cmd.row;
      out_data.last_of_frame <= cmd.last_row;
      out_data.stream_done   <= done_r;
    end
  end

  assign out_valid = out_valid_r;

  always_comb begin
    status.start     = accept && window;
    status.out_busy  = out_valid_r && !out_ready;
    status.taps      = taps;
    status.spacing   = d_eff;
    status.frame_len = fl_eff;
    status.out_len   = ol_eff;
  end

endmodule

@@ design/tdnn_layer_stream_core.sv @@
// top level of the streaming dilated tdnn layer
`timescale 1ns / 1ps
// Load, bias and mid-frame feed requests are taken whenever the block is
// idle. A request that completes a frame and fills the window occupies the
// block while it computes every output row: one multiply-accumulate per cycle
// on the single MAC, fed by one read port of the weight ram and one of the
// frame history ram, over every tap and feature element, then a tail per row
// for pipeline drain, rounding, activation and the output register. in_ready
// is high only while no frame computation is running; an output waiting to be
// taken stalls the next row, not the input.
module tdnn_layer_stream_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  tls_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output tls_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_addr,
  input  logic [15:0]        cfg_wdata
);
  import tls_pkg::*;

  tls_cmd_t    cmd;
  tls_status_t status;

  assign in_ready = cmd.idle;

  tls_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .cmd    (cmd)
  );

  tls_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .status    (status)
  );

endmodule
